// ===== hdl/fixed_block_free_list_allocator_macros.svh =====
// Assertion macros shared by the allocator checker.
// No dependencies; include by bare file name.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBFL_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fbfl_pkg.sv =====
// Types and constants of the fixed block free list allocator.
// No dependencies; used by every other file but the macro header and fbfl_ram, through scoped names.
package fbfl_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned WORD_BYTES = 8;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned OFS_W    = 20;
  localparam int unsigned POOL_W   = 21;
  localparam int unsigned BLK_W    = 17;
  localparam int unsigned STRIDE_W = 17;
  localparam int unsigned PROD_W   = IDX_W + STRIDE_W;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 21;

  localparam int unsigned DIV_STEPS = POOL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]    END_MARK     = CNT_W'(MAX_BLOCKS);
  localparam logic [POOL_W-1:0]   HEADER_BYTES = POOL_W'(3 * WORD_BYTES);
  localparam logic [PROD_W-1:0]   PAYLOAD_BASE = PROD_W'(4 * WORD_BYTES);
  localparam logic [BLK_W-1:0]    BLOCK_CAP    = BLK_W'(65536);
  localparam logic [STRIDE_W:0]   WORD_MASK    = (STRIDE_W + 1)'(WORD_BYTES - 1);
  localparam logic [POOL_W-1:0]   COUNT_CAP    = POOL_W'(MAX_BLOCKS);

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic div_step;
    logic link_wr;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
    logic link_last;
    logic count_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/fbfl_if.sv =====
// Handshake channels of the allocator: request, response, configuration.
// Depends on fbfl_pkg for widths.
interface fbfl_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [fbfl_pkg::IDX_W-1:0]  block_index;
  modport source (output valid, action, block_index, input ready);
  modport sink   (input valid, action, block_index, output ready);
endinterface

interface fbfl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [fbfl_pkg::IDX_W-1:0]  granted_index;
  logic [fbfl_pkg::OFS_W-1:0]  granted_offset;
  logic [fbfl_pkg::CNT_W-1:0]  free_count;
  logic [fbfl_pkg::CNT_W-1:0]  total_blocks;
  modport source (output valid, status, granted_index, granted_offset, free_count,
                  total_blocks, input ready);
  modport sink   (input valid, status, granted_index, granted_offset, free_count,
                  total_blocks, output ready);
endinterface

interface fbfl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fbfl_pkg::CFG_IDX_W-1:0]   index;
  logic [fbfl_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/fbfl_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module fbfl_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fbfl_div.sv =====
// Restoring divider, one quotient bit per step, for the block count.
// Depends on fbfl_pkg.
module fbfl_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           step_i,
  input  logic [fbfl_pkg::POOL_W-1:0]    num_i,
  input  logic [fbfl_pkg::STRIDE_W-1:0]  den_i,
  output logic [fbfl_pkg::POOL_W-1:0]    quo_o,
  output logic                           last_o
);

  logic [fbfl_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [fbfl_pkg::STRIDE_W-1:0]  rem_q, rem_d;
  logic [fbfl_pkg::POOL_W-1:0]    nq_q;
  logic [fbfl_pkg::STRIDE_W:0]    rem_sh;
  logic                           qbit;

  always_comb begin
    rem_sh = {rem_q, nq_q[fbfl_pkg::POOL_W-1]};
    qbit   = (rem_sh >= {1'b0, den_i});
    rem_d  = qbit ? fbfl_pkg::STRIDE_W'(rem_sh - {1'b0, den_i})
                  : rem_sh[fbfl_pkg::STRIDE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // remainder and dividend/quotient share a shift path
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nq_q  <= num_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      nq_q  <= {nq_q[fbfl_pkg::POOL_W-2:0], qbit};
    end
  end

  assign quo_o  = nq_q;
  assign last_o = (cnt_q == fbfl_pkg::DIV_CNT_W'(fbfl_pkg::DIV_STEPS - 1));

endmodule

// ===== hdl/fbfl_dp.sv =====
// Allocator datapath: config registers, list state, link RAM, divider, result register.
// Depends on fbfl_pkg, fbfl_ram and fbfl_div.
module fbfl_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       req_action_i,
  input  logic [fbfl_pkg::IDX_W-1:0]       req_block_index_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output logic [1:0]                       status_o,
  output logic [fbfl_pkg::IDX_W-1:0]       granted_index_o,
  output logic [fbfl_pkg::OFS_W-1:0]       granted_offset_o,
  output logic [fbfl_pkg::CNT_W-1:0]       free_count_o,
  output logic [fbfl_pkg::CNT_W-1:0]       total_blocks_o,
  input  fbfl_pkg::cmd_t                   cmd_i,
  output fbfl_pkg::sts_t                   sts_o
);

  localparam int unsigned IW = fbfl_pkg::IDX_W;
  localparam int unsigned CW = fbfl_pkg::CNT_W;
  localparam int unsigned SW = fbfl_pkg::STRIDE_W;

  // configuration
  logic [fbfl_pkg::POOL_W-1:0] pool_q;
  logic [fbfl_pkg::BLK_W-1:0]  blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= '0;
      blk_q  <= fbfl_pkg::BLK_W'(8);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fbfl_pkg::REG_POOL_BYTES:  pool_q <= cfg_data_i[fbfl_pkg::POOL_W-1:0];
        fbfl_pkg::REG_BLOCK_BYTES: blk_q  <= cfg_data_i[fbfl_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // list state
  logic [CW-1:0] head_q, head_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] total_q, total_d;
  logic [SW-1:0] stride_q;

  // current item
  logic [1:0]                    act_q;
  logic [IW-1:0]                 idx_q;
  logic [fbfl_pkg::PROD_W-1:0]   prod_q;
  logic [IW-1:0]                 link_i_q;

  // init arithmetic
  logic [fbfl_pkg::BLK_W-1:0]  req_sat;
  logic [SW:0]                 rounded;
  logic [SW-1:0]               stride_new;
  logic [fbfl_pkg::POOL_W-1:0] num_new;
  logic [fbfl_pkg::POOL_W-1:0] quo;
  logic [CW-1:0]               cnt_sat;
  logic                        div_last;

  always_comb begin
    req_sat    = (blk_q > fbfl_pkg::BLOCK_CAP) ? fbfl_pkg::BLOCK_CAP : blk_q;
    rounded    = ({1'b0, req_sat} + fbfl_pkg::WORD_MASK) & ~fbfl_pkg::WORD_MASK;
    stride_new = SW'(rounded + (SW + 1)'(fbfl_pkg::WORD_BYTES));
    num_new    = (pool_q >= fbfl_pkg::HEADER_BYTES) ? (pool_q - fbfl_pkg::HEADER_BYTES) : '0;
    cnt_sat    = (quo > fbfl_pkg::COUNT_CAP) ? fbfl_pkg::END_MARK : quo[CW-1:0];
  end

  fbfl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .step_i  (cmd_i.div_step),
    .num_i   (num_new),
    .den_i   (stride_q),
    .quo_o   (quo),
    .last_o  (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= SW'(16);
    end else if (cmd_i.start && (req_action_i == fbfl_pkg::ACT_INIT)) begin
      stride_q <= stride_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q  <= req_action_i;
      idx_q  <= req_block_index_i;
      prod_q <= fbfl_pkg::PROD_W'(head_q[IW-1:0]) * fbfl_pkg::PROD_W'(stride_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      link_i_q <= '0;
    end else if (cmd_i.link_wr) begin
      link_i_q <= link_i_q + 1'b1;
    end
  end

  // link RAM
  logic [CW-1:0] link_next;
  logic [CW-1:0] ram_rdata;
  logic [CW-1:0] ram_wdata;
  logic [IW-1:0] ram_addr;
  logic          ram_we;
  logic          commit_wr;

  assign link_next = (({1'b0, link_i_q} + 1'b1) < cnt_sat) ? ({1'b0, link_i_q} + 1'b1)
                                                           : fbfl_pkg::END_MARK;

  always_comb begin
    if (cmd_i.link_wr) begin
      ram_addr  = link_i_q;
      ram_wdata = link_next;
    end else if (cmd_i.commit && commit_wr) begin
      ram_addr  = idx_q;
      ram_wdata = head_q;
    end else begin
      ram_addr  = head_q[IW-1:0];
      ram_wdata = head_q;
    end
    ram_we = cmd_i.link_wr | (cmd_i.commit & commit_wr);
  end

  fbfl_ram #(
    .WIDTH (CW),
    .DEPTH (fbfl_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.start),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // result of the current item
  logic [1:0]               status_d;
  logic [IW-1:0]            gidx_d;
  logic [fbfl_pkg::OFS_W-1:0] gofs_d;
  logic [fbfl_pkg::PROD_W-1:0] ofs_full;

  assign ofs_full = fbfl_pkg::PAYLOAD_BASE + prod_q;

  always_comb begin
    head_d    = head_q;
    free_d    = free_q;
    total_d   = total_q;
    status_d  = fbfl_pkg::ST_OK;
    gidx_d    = '0;
    gofs_d    = '0;
    commit_wr = 1'b0;
    case (act_q)
      fbfl_pkg::ACT_INIT: begin
        head_d  = (cnt_sat == '0) ? fbfl_pkg::END_MARK : '0;
        total_d = cnt_sat;
        free_d  = cnt_sat;
      end
      fbfl_pkg::ACT_ALLOC: begin
        if ((head_q >= total_q) || (free_q == '0)) begin
          status_d = fbfl_pkg::ST_EMPTY;
        end else begin
          // a link past the count ends the list
          head_d = (ram_rdata < total_q) ? ram_rdata : fbfl_pkg::END_MARK;
          free_d = free_q - 1'b1;
          gidx_d = head_q[IW-1:0];
          gofs_d = ofs_full[fbfl_pkg::OFS_W-1:0];
        end
      end
      fbfl_pkg::ACT_FREE: begin
        if ({1'b0, idx_q} >= total_q) begin
          status_d = fbfl_pkg::ST_BAD_INDEX;
        end else begin
          commit_wr = 1'b1;
          head_d    = {1'b0, idx_q};
          if (free_q < total_q) begin
            free_d = free_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  logic rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= fbfl_pkg::END_MARK;
      free_q      <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      head_q      <= head_d;
      free_q      <= free_d;
      total_q     <= total_d;
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o         <= status_d;
      granted_index_o  <= gidx_d;
      granted_offset_o <= gofs_d;
      free_count_o     <= free_d;
      total_blocks_o   <= total_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    sts_o            = '0;
    sts_o.div_last   = div_last;
    sts_o.link_last  = ({1'b0, link_i_q} == (cnt_sat - 1'b1));
    sts_o.count_zero = (cnt_sat == '0);
    sts_o.out_free   = ~rsp_valid_q | rsp_ready_i;
  end

endmodule

// ===== hdl/fbfl_ctrl.sv =====
// Allocator controller: sequences accept, divide, link sweep and commit.
// Depends on fbfl_pkg.
module fbfl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic [1:0]     req_action_i,
  output logic           req_ready_o,
  input  fbfl_pkg::sts_t sts_i,
  output fbfl_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_LINK = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = (req_action_i == fbfl_pkg::ACT_INIT) ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.link_wr = ~sts_i.count_zero;
        if (sts_i.count_zero || sts_i.link_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the item
        cmd_o.commit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/fixed_block_free_list_allocator.sv =====
// Top level of the fixed block free list allocator.
// Depends on fbfl_pkg, fbfl_if, fbfl_ctrl and fbfl_dp.
//
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   action, block_index
//  rsp_o    out  valid/ready   status, granted_index, granted_offset, free_count, total_blocks
//  cfg_i    in   valid/ready   index, data (0 pool_bytes, 1 block_bytes)
//
// Allocate, free and no-op are an accept and then a commit after the registered
// link RAM read. Init is an accept, 21 steps of the bit-serial divider, a sweep
// that makes one link RAM write per block, then a commit. Reset needs no clearing
// pass. A result waits in the output register; commit holds while it is not taken.
// Config writes are always ready.
module fixed_block_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbfl_req_if.sink    req_i,
  fbfl_rsp_if.source  rsp_o,
  fbfl_cfg_if.sink    cfg_i
);

  fbfl_pkg::cmd_t cmd;
  fbfl_pkg::sts_t sts;

  fbfl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  fbfl_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .cfg_ready_o       (cfg_i.ready),
    .req_action_i      (req_i.action),
    .req_block_index_i (req_i.block_index),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .status_o          (rsp_o.status),
    .granted_index_o   (rsp_o.granted_index),
    .granted_offset_o  (rsp_o.granted_offset),
    .free_count_o      (rsp_o.free_count),
    .total_blocks_o    (rsp_o.total_blocks),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

// ===== hdl/fbfl_checker.sv =====
// Port-level checks on the allocator, bound to the top level.
// Depends on fbfl_pkg and fixed_block_free_list_allocator_macros.svh.
`include "fixed_block_free_list_allocator_macros.svh"

module fbfl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [1:0]                   status_i,
  input logic [fbfl_pkg::IDX_W-1:0]   granted_index_i,
  input logic [fbfl_pkg::OFS_W-1:0]   granted_offset_i,
  input logic [fbfl_pkg::CNT_W-1:0]   free_count_i,
  input logic [fbfl_pkg::CNT_W-1:0]   total_blocks_i
);

  `FBFL_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "rsp dropped")
  `FBFL_ASSERT(a_fail_no_grant, clk_i, rst_ni, rsp_valid_i && (status_i != fbfl_pkg::ST_OK), (granted_index_i == '0) && (granted_offset_i == '0), "grant on failure")
  `FBFL_ASSERT(a_free_le_total, clk_i, rst_ni, rsp_valid_i, free_count_i <= total_blocks_i, "free count above total")
  `FBFL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "ready right after accept")

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .granted_index_i  (rsp_o.granted_index),
  .granted_offset_i (rsp_o.granted_offset),
  .free_count_i     (rsp_o.free_count),
  .total_blocks_i   (rsp_o.total_blocks)
);
